/* hw/rtl/fts_pkg.sv */
// Shared types, constants and helpers of the force/torque calibration block.
`timescale 1ns / 1ps
package fts_pkg;

  localparam int AXES   = 6;
  localparam int MATSZ  = AXES * AXES;
  localparam int DIVW   = 64;
  localparam int DVSW   = 40;
  localparam int MULAW  = 33;
  localparam int MULBW  = 26;
  localparam int PRODW  = MULAW + MULBW;
  localparam int GAINW  = 24;

  localparam logic [1:0] CMD_COEF   = 2'd0;
  localparam logic [1:0] CMD_UNLOAD = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [2:0] ST_FORCES  = 3'd0;
  localparam logic [2:0] ST_COEF    = 3'd1;
  localparam logic [2:0] ST_OFS_ACC = 3'd2;
  localparam logic [2:0] ST_OFS_DONE = 3'd3;
  localparam logic [2:0] ST_ZERO_EXC = 3'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         sensor;
    logic [15:0]        gauge_0;
    logic [15:0]        gauge_1;
    logic [15:0]        gauge_2;
    logic [15:0]        gauge_3;
    logic [15:0]        gauge_4;
    logic [15:0]        gauge_5;
    logic [15:0]        excitation;
    logic [5:0]         coef_index;
    logic signed [31:0] coef_value;
  } fts_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         sensor_out;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
  } fts_out_t;

  typedef struct packed {
    logic            start;
    logic [DIVW-1:0] dividend;
    logic [DVSW-1:0] divisor;
  } div_req_t;

  function automatic logic [15:0] gauge_sel(fts_in_t it, logic [2:0] idx);
    logic [15:0] g;
    case (idx)
      3'd0:    g = it.gauge_0;
      3'd1:    g = it.gauge_1;
      3'd2:    g = it.gauge_2;
      3'd3:    g = it.gauge_3;
      3'd4:    g = it.gauge_4;
      default: g = it.gauge_5;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] sat_q(logic neg, logic [DIVW-1:0] q);
    logic [31:0] r;
    if (neg) begin
      if (q >= DIVW'(64'h8000_0000)) r = 32'h8000_0000;
      else                           r = 32'(-q);
    end else begin
      if (q > DIVW'(64'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else                          r = q[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fts_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fts_div
  import fts_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  div_req_t        req,
  output logic            done,
  output logic [DIVW-1:0] quotient
);

  logic            busy_r;
  logic            done_r;
  logic [5:0]      cnt_r;
  logic [DVSW-1:0] rem_r;
  logic [DIVW-1:0] quo_r;
  logic [DVSW-1:0] dvs_r;
  logic [DVSW:0]   trial;
  logic            fits;

  assign trial = {rem_r, quo_r[DIVW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DVSW'(trial - {1'b0, dvs_r}) : trial[DVSW-1:0];
      quo_r <= {quo_r[DIVW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* hw/rtl/force_torque_sensor_calibration_top.sv */
// Sequence: coefficient writes and offset samples use no divider, except the sample that
// completes the average, which runs six divisions; a loaded sample with nonzero gain and
// excitation runs 36 multiply-accumulate steps plus six divisions on the shared divider.
// Throughput: one item at a time; the next is taken once the result enters the output register.
// Reset: synchronous active low; clears control, offsets, counts and coefficient
// valid bits at once, gain returns to 1.0; no clearing pass.
`timescale 1ns / 1ps
module force_torque_sensor_calibration_top
  import fts_pkg::*;
#(
  parameter int SENSORS        = 4,
  parameter int OFFSET_SAMPLES = 100
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fts_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fts_out_t         out_data,
  input  logic             cfg_we,
  input  logic [GAINW-1:0] cfg_wdata
);

  localparam int MDEPTH = SENSORS * MATSZ;
  localparam int AW     = $clog2(MDEPTH);
  localparam int ODEPTH = SENSORS * AXES;
  localparam int OW     = $clog2(ODEPTH);
  localparam int SW     = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_COEF     = 13'b0000000000010,
    S_OFS_ADD  = 13'b0000000000100,
    S_OFS_DIV  = 13'b0000000001000,
    S_OFS_WAIT = 13'b0000000010000,
    S_MEAS_D   = 13'b0000000100000,
    S_MEAS_LD  = 13'b0000001000000,
    S_MAC_RD   = 13'b0000010000000,
    S_MAC_MUL  = 13'b0000100000000,
    S_MAC_ACC  = 13'b0001000000000,
    S_DIV      = 13'b0010000000000,
    S_DIV_WAIT = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [GAINW-1:0]  gain_r;
  fts_in_t           item_r;
  logic [2:0]        status_r;
  logic [31:0]       force_r [AXES];
  logic [2:0]        row_r;
  logic [2:0]        col_r;
  logic              out_valid_r;
  fts_out_t          out_data_r;

  logic signed [31:0] mem [MDEPTH];
  logic [MDEPTH-1:0]  vld_r;
  logic signed [31:0] coef_rd_r;
  logic               coef_vld_r;

  logic [22:0]       ofs_sum_r [ODEPTH];
  logic [23:0]       ofs_val_r [ODEPTH];
  logic [6:0]        ofs_cnt_r [SENSORS];

  logic signed [MULBW-1:0] diff_r;
  logic signed [PRODW-1:0] prod_r;
  logic [DVSW-1:0]         d_r;
  logic signed [DIVW-1:0]  acc_r;

  logic signed [MULAW-1:0] mul_a;
  logic signed [MULBW-1:0] mul_b;

  div_req_t         dreq;
  logic             ddone;
  logic [DIVW-1:0]  dquo;

  logic [AW-1:0]    mac_addr;
  logic [AW-1:0]    wr_addr;
  logic [OW-1:0]    col_idx;
  logic [SW-1:0]    sidx;
  logic [6:0]       cnt_inc;
  logic             acc_neg;
  logic [DIVW-1:0]  acc_mag;
  logic             in_xfer;
  logic             sensor_ok;
  logic             out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign sensor_ok = {2'b00, in_data.sensor} < 4'(SENSORS);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign sidx     = SW'(item_r.sensor);
  assign mac_addr = AW'(32'(item_r.sensor) * MATSZ + 32'(row_r) * AXES + 32'(col_r));
  assign wr_addr  = AW'(32'(item_r.sensor) * MATSZ + 32'(item_r.coef_index));
  assign col_idx  = OW'(32'(item_r.sensor) * AXES + 32'(col_r));
  assign cnt_inc  = ofs_cnt_r[sidx] + 7'd1;
  assign acc_neg  = acc_r[DIVW-1];
  assign acc_mag  = acc_neg ? DIVW'(-acc_r) : DIVW'(acc_r);

  always_comb begin
    if (state_r == S_MEAS_D) begin
      mul_a = MULAW'({9'b0, gain_r});
      mul_b = MULBW'({10'b0, item_r.excitation});
    end else begin
      mul_a = MULAW'(coef_vld_r ? coef_rd_r : 32'sd0);
      mul_b = diff_r;
    end
  end

  always_comb begin
    dreq.start    = (state_r == S_OFS_DIV) || (state_r == S_DIV);
    dreq.dividend = acc_mag + DIVW'(d_r >> 1);
    dreq.divisor  = d_r;
    if (state_r == S_OFS_DIV) begin
      dreq.dividend = DIVW'({ofs_sum_r[col_idx], 8'b0}) + DIVW'(OFFSET_SAMPLES / 2);
      dreq.divisor  = DVSW'(OFFSET_SAMPLES);
    end
  end

  fts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .done     (ddone),
    .quotient (dquo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_data.command != CMD_NONE && sensor_ok) begin
          case (in_data.command)
            CMD_COEF:   state_nxt = S_COEF;
            CMD_UNLOAD: state_nxt = S_OFS_ADD;
            default: begin
              if (gain_r == '0 || in_data.excitation == '0) state_nxt = S_OUT;
              else                                          state_nxt = S_MEAS_D;
            end
          endcase
        end
      end
      S_COEF:     state_nxt = S_OUT;
      S_OFS_ADD:  state_nxt = (cnt_inc >= 7'(OFFSET_SAMPLES)) ? S_OFS_DIV : S_OUT;
      S_OFS_DIV:  state_nxt = S_OFS_WAIT;
      S_OFS_WAIT: if (ddone) state_nxt = (col_r == 3'(AXES - 1)) ? S_OUT : S_OFS_DIV;
      S_MEAS_D:   state_nxt = S_MEAS_LD;
      S_MEAS_LD:  state_nxt = S_MAC_RD;
      S_MAC_RD:   state_nxt = S_MAC_MUL;
      S_MAC_MUL:  state_nxt = S_MAC_ACC;
      S_MAC_ACC:  state_nxt = (col_r == 3'(AXES - 1)) ? S_DIV : S_MAC_RD;
      S_DIV:      state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (ddone) state_nxt = (row_r == 3'(AXES - 1)) ? S_OUT : S_MAC_RD;
      S_OUT:      state_nxt = out_load ? S_IDLE : S_OUT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_COEF && item_r.coef_index < 6'(MATSZ)) begin
      mem[wr_addr] <= item_r.coef_value;
    end
    coef_rd_r <= mem[mac_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      coef_vld_r <= 1'b0;
    end else begin
      if (state_r == S_COEF && item_r.coef_index < 6'(MATSZ)) vld_r[wr_addr] <= 1'b1;
      coef_vld_r <= vld_r[mac_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAINW'(256);
      out_valid_r <= 1'b0;
      for (int i = 0; i < ODEPTH; i++) begin
        ofs_sum_r[i] <= '0;
        ofs_val_r[i] <= '0;
      end
      for (int i = 0; i < SENSORS; i++) ofs_cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) gain_r <= cfg_wdata;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            item_r <= in_data;
            row_r  <= '0;
            col_r  <= '0;
            acc_r  <= '0;
            for (int i = 0; i < AXES; i++) force_r[i] <= '0;
            status_r <= (in_data.command == CMD_COEF)   ? ST_COEF :
                        (in_data.command == CMD_UNLOAD) ? ST_OFS_ACC : ST_ZERO_EXC;
          end
        end
        S_OFS_ADD: begin
          for (int k = 0; k < AXES; k++) begin
            ofs_sum_r[OW'(32'(item_r.sensor) * AXES + k)] <=
              ofs_sum_r[OW'(32'(item_r.sensor) * AXES + k)] +
              23'(gauge_sel(item_r, 3'(k)));
          end
          if (cnt_inc >= 7'(OFFSET_SAMPLES)) begin
            ofs_cnt_r[sidx] <= '0;
            status_r        <= ST_OFS_DONE;
          end else begin
            ofs_cnt_r[sidx] <= cnt_inc;
          end
        end
        S_OFS_WAIT: begin
          if (ddone) begin
            ofs_val_r[col_idx] <= dquo[23:0];
            ofs_sum_r[col_idx] <= '0;
            col_r              <= col_r + 3'd1;
          end
        end
        S_MEAS_D: begin
          prod_r   <= mul_a * mul_b;
          status_r <= ST_FORCES;
        end
        S_MEAS_LD: d_r <= prod_r[DVSW-1:0];
        S_MAC_RD: begin
          diff_r <= $signed({2'b00, gauge_sel(item_r, col_r), 8'b0}) -
                    $signed({2'b00, ofs_val_r[col_idx]});
        end
        S_MAC_MUL: prod_r <= mul_a * mul_b;
        S_MAC_ACC: begin
          acc_r <= acc_r + DIVW'(prod_r);
          if (col_r != 3'(AXES - 1)) col_r <= col_r + 3'd1;
        end
        S_DIV_WAIT: begin
          if (ddone) begin
            force_r[row_r] <= sat_q(acc_neg, dquo);
            acc_r          <= '0;
            col_r          <= '0;
            row_r          <= row_r + 3'd1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data_r.status     <= status_r;
            out_data_r.sensor_out <= item_r.sensor;
            out_data_r.force_x    <= force_r[0];
            out_data_r.force_y    <= force_r[1];
            out_data_r.force_z    <= force_r[2];
            out_data_r.torque_x   <= force_r[3];
            out_data_r.torque_y   <= force_r[4];
            out_data_r.torque_z   <= force_r[5];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/force_torque_sensor_calibration_top_test.sv */
// Self-checking testbench for the force/torque sensor calibration block.
`timescale 1ns / 1ps
module force_torque_sensor_calibration_top_test;
  import fts_pkg::*;

  localparam int NSENS = 4;
  localparam int NAVG = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 20000;

  class cal_scoreboard;
    logic signed [31:0] coef[NSENS][MATSZ];
    logic [22:0] ofs_sum[NSENS][AXES];
    logic [23:0] ofs_val[NSENS][AXES];
    int ofs_cnt[NSENS];
    logic [GAINW-1:0] gain;
    fts_out_t expected_q[$];
    int errors;
    int results;
    int forces_seen;
    int offsets_done;
    int saturated;

    function new();
      foreach (coef[s, k]) coef[s][k] = '0;
      foreach (ofs_sum[s, k]) begin
        ofs_sum[s][k] = '0;
        ofs_val[s][k] = '0;
      end
      foreach (ofs_cnt[s]) ofs_cnt[s] = 0;
      gain = 24'd256;
    endfunction

    function logic signed [31:0] scale_axis(longint s, longint unsigned d);
      longint unsigned mag;
      longint unsigned q;
      mag = (s < 0) ? longint'(-s) : s;
      q = (mag + d / 2) / d;
      if (s < 0) begin
        if (q >= 64'h8000_0000) begin
          saturated++;
          return 32'sh8000_0000;
        end
        return -$signed(q[31:0]);
      end
      if (q > 64'h7FFF_FFFF) begin
        saturated++;
        return 32'sh7FFF_FFFF;
      end
      return $signed(q[31:0]);
    endfunction

    function void note_input(fts_in_t it);
      fts_out_t r;
      logic [15:0] g[AXES];
      logic signed [31:0] f[AXES];
      longint diff[AXES];
      longint acc;
      longint unsigned d;
      int sn;
      if (it.command == CMD_NONE) return;
      sn = int'(it.sensor);
      g[0] = it.gauge_0; g[1] = it.gauge_1; g[2] = it.gauge_2;
      g[3] = it.gauge_3; g[4] = it.gauge_4; g[5] = it.gauge_5;
      r = '0;
      r.sensor_out = it.sensor;
      case (it.command)
        CMD_COEF: begin
          if (it.coef_index < MATSZ) coef[sn][it.coef_index] = it.coef_value;
          r.status = ST_COEF;
        end
        CMD_UNLOAD: begin
          for (int k = 0; k < AXES; k++) ofs_sum[sn][k] = ofs_sum[sn][k] + 23'(g[k]);
          ofs_cnt[sn]++;
          if (ofs_cnt[sn] >= NAVG) begin
            for (int k = 0; k < AXES; k++) begin
              ofs_val[sn][k] = 24'(((longint'(ofs_sum[sn][k]) << 8) + NAVG / 2) / NAVG);
              ofs_sum[sn][k] = '0;
            end
            ofs_cnt[sn] = 0;
            offsets_done++;
            r.status = ST_OFS_DONE;
          end else begin
            r.status = ST_OFS_ACC;
          end
        end
        default: begin
          d = longint'(gain) * longint'(it.excitation);
          if (d == 0) begin
            r.status = ST_ZERO_EXC;
          end else begin
            for (int k = 0; k < AXES; k++)
              diff[k] = longint'(g[k]) * 256 - longint'(ofs_val[sn][k]);
            for (int i = 0; i < AXES; i++) begin
              acc = 0;
              for (int j = 0; j < AXES; j++) acc += longint'(coef[sn][i * AXES + j]) * diff[j];
              f[i] = scale_axis(acc, d);
            end
            r.status = ST_FORCES;
            r.force_x = f[0]; r.force_y = f[1]; r.force_z = f[2];
            r.torque_x = f[3]; r.torque_y = f[4]; r.torque_z = f[5];
            forces_seen++;
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(fts_out_t a);
      fts_out_t e;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", a);
        return;
      end
      e = expected_q.pop_front();
      if (a.status !== e.status || a.sensor_out !== e.sensor_out ||
          a.force_x !== e.force_x || a.force_y !== e.force_y ||
          a.force_z !== e.force_z || a.torque_x !== e.torque_x ||
          a.torque_y !== e.torque_y || a.torque_z !== e.torque_z) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d differs", results);
          $display("  expected: %p", e);
          $display("  actual:   %p", a);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fts_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fts_out_t out_data;
  logic cfg_we = 1'b0;
  logic [GAINW-1:0] cfg_wdata = '0;

  cal_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int focus_sensor = 0;

  force_torque_sensor_calibration_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (rst_n && ((out_valid && out_ready) || (in_valid && in_ready) || cfg_we))
      idle_cycles = 0;
    else if (rst_n)
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("force_torque_sensor_calibration_top: mismatch");
      $finish;
    end
  end

  task automatic send(fts_in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_gain(logic [GAINW-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.gain = v;
  endtask

  function automatic fts_in_t make_item(logic [1:0] cmd, logic [1:0] sn);
    fts_in_t it;
    it.command = cmd;
    it.sensor = sn;
    it.gauge_0 = 16'($urandom); it.gauge_1 = 16'($urandom); it.gauge_2 = 16'($urandom);
    it.gauge_3 = 16'($urandom); it.gauge_4 = 16'($urandom); it.gauge_5 = 16'($urandom);
    case ($urandom_range(19))
      0:       it.excitation = 16'd0;
      1, 2:    it.excitation = 16'($urandom_range(1, 15));
      default: it.excitation = 16'($urandom);
    endcase
    it.coef_index = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(35));
    if ($urandom_range(7) == 0) it.coef_value = $signed($urandom);
    else it.coef_value = $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
    return it;
  endfunction

  function automatic fts_in_t random_item();
    int p;
    logic [1:0] sn;
    p = $urandom_range(99);
    if ($urandom_range(119) == 0) focus_sensor = $urandom_range(NSENS - 1);
    sn = ($urandom_range(3) == 0) ? 2'($urandom_range(NSENS - 1)) : 2'(focus_sensor);
    if (p < 25) return make_item(CMD_COEF, sn);
    if (p < 65) return make_item(CMD_UNLOAD, sn);
    if (p < 96) return make_item(CMD_LOAD, sn);
    return make_item(CMD_NONE, sn);
  endfunction

  task automatic random_phase(int n);
    fts_in_t it;
    int sent;
    sent = 0;
    while (sent < n) begin
      it = random_item();
      send(it);
      if (it.command != CMD_NONE) sent++;
      if (sent == n / 2 && $urandom_range(1) == 0) drain();
    end
  endtask

  initial begin
    fts_in_t it;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    it = make_item(CMD_LOAD, 2'd0);
    it.gauge_0 = 16'hFFFF; it.excitation = 16'hFFFF;
    send(it);
    for (int k = 0; k < 6; k++) begin
      it = make_item(CMD_COEF, 2'(k % 4));
      it.coef_index = (k == 0) ? 6'd0 : (k == 1) ? 6'd35 : (k == 2) ? 6'd63 : 6'(k * 7);
      it.coef_value = k[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      send(it);
    end
    it = make_item(CMD_COEF, 2'd3);
    it.coef_index = 6'd14; it.coef_value = 32'sh0001_0000;
    send(it);
    it = make_item(CMD_LOAD, 2'd3);
    it.excitation = 16'd0;
    send(it);
    it = make_item(CMD_NONE, 2'd1);
    send(it);
    it = make_item(CMD_UNLOAD, 2'd2);
    it.gauge_0 = 16'hFFFF; it.gauge_5 = 16'h0000;
    send(it);
    it = make_item(CMD_LOAD, 2'd0);
    it.gauge_0 = 16'd0; it.gauge_1 = 16'hFFFF; it.gauge_2 = 16'd0;
    it.gauge_3 = 16'hFFFF; it.gauge_4 = 16'd0; it.gauge_5 = 16'hFFFF;
    it.excitation = 16'd1;
    send(it);

    set_gain(24'd1);
    for (int k = 0; k < 4; k++) begin
      it = make_item(CMD_LOAD, 2'(k));
      it.excitation = k[0] ? 16'hFFFF : 16'd1;
      send(it);
    end
    set_gain(24'hFFFFFF);
    for (int k = 0; k < 4; k++) begin
      it = make_item(CMD_LOAD, 2'(k));
      it.excitation = k[0] ? 16'hFFFF : 16'd1;
      send(it);
    end

    set_gain(24'($urandom_range(1, 24'hFFFFFF)));
    tx_idle_pct = 12;
    rx_idle_pct = 64;
    random_phase(340);

    set_gain(24'd256);
    tx_idle_pct = 64;
    rx_idle_pct = 12;
    random_phase(340);

    set_gain(24'($urandom_range(1, 2048)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1;
    random_phase(340);

    drain();
    $display("sent %0d items, checked %0d results: %0d force sets, %0d saturated axes,",
             items_sent, sb.results, sb.forces_seen, sb.saturated);
    $display("%0d completed offset averages, gain at 1, 1.0, max and random values",
             sb.offsets_done);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("force_torque_sensor_calibration_top: match");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("force_torque_sensor_calibration_top: mismatch");
    end
    $finish;
  end

endmodule
